[rtl/core/rsm_pkg.sv]
// ----------------------------------------------------------------------------
// rsm_pkg: shared types for the row softmax core
// Sequencer states, divider request/response structs and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rsm_pkg;

  localparam int unsigned DvdW = 33;  // dividend and quotient width
  localparam int unsigned DvsW = 24;  // divisor width

  localparam logic [15:0] NegInfBits = 16'hFC00;
  localparam logic [15:0] PosMaxBits = 16'h7BFF;
  localparam logic [31:0] Q31One     = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,   // load elements
    S_RD,     // read stored element
    S_DIFF,   // difference to row max
    S_MUL,    // series product y*r
    S_DIVS,   // start divide by k
    S_DIVW,   // wait for quotient
    S_SQ,     // square product
    S_SQR,    // round square
    S_EXPW,   // write exp value, accumulate
    S_RECS,   // start reciprocal
    S_RECW,   // wait for reciprocal
    S_ORD,    // read exp value
    S_OMUL,   // exp times reciprocal
    S_OCONV,  // convert small or start normalize
    S_ONORM,  // normalize one bit a cycle
    S_OEMIT   // hand item to output register
  } rsm_state_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/rsm_div.sv]
// ----------------------------------------------------------------------------
// rsm_div: restoring unsigned divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rsm_pkg::div_req_t req_i,
  output      rsm_pkg::div_rsp_t rsp_o
);
  import rsm_pkg::*;

  localparam logic [5:0] LastCnt = 6'(DvdW - 1);

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvsW:0]   rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      // shift quotient bit in where the dividend bit leaves
      rem_q <= ge ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

`default_nettype wire

[rtl/core/row_softmax_fp16_core.sv]
// ----------------------------------------------------------------------------
// row_softmax_fp16_core: softmax over rows of half-precision elements
// Fixed-point exp table by series, shared multiplier and divider.
// ----------------------------------------------------------------------------
// Elements load at one per cycle while a row fills; the row max is tracked on
// the fly. When row_length elements are held, the block stalls its input and
// runs two passes. In the sum pass each element takes twelve series steps,
// each waiting on the radix-2 divider, plus four squarings on the shared
// 33x32 multiplier. A reciprocal on the divider follows. The emit pass
// normalizes the product one bit a cycle when it is too large for the direct
// conversion, and an output stall can hold it.
`default_nettype none

module row_softmax_fp16_core #(
  parameter int unsigned MAX_ROW = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [15:0] x_bits_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [15:0] y_bits_o,
  output      logic        row_last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import rsm_pkg::*;

  localparam int unsigned AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int unsigned CW = $clog2(MAX_ROW + 1);
  localparam logic [6:0]  MaxLen = 7'(MAX_ROW);
  localparam logic signed [43:0] NegInfVal = -(44'sd1 <<< 42);

  function automatic logic signed [43:0] half_val(input logic [15:0] b);
    logic [43:0] mag;
    mag = '0;
    if (b[14:10] == 5'h1F) mag = 44'd1 << 42;
    else if (b[14:10] == 5'd0) mag = {34'd0, b[9:0]};
    else mag = {33'd0, 1'b1, b[9:0]} << (b[14:10] - 5'd1);
    return b[15] ? -$signed(mag) : $signed(mag);
  endfunction

  rsm_state_e state_q, state_d;

  logic [6:0]    row_len_q;
  logic [CW-1:0] fill_q, n_q;
  logic [AW-1:0] idx_q;
  logic signed [43:0] vmax_q;
  logic [23:0]   sum_q;
  logic [15:0]   st_mem [MAX_ROW];
  logic [15:0]   ex_mem [MAX_ROW];
  logic [15:0]   st_rd_q, ex_rd_q;
  logic [31:0]   y_q, r_q;
  logic [3:0]    k_q;
  logic [1:0]    sq_q;
  logic [32:0]   inv_q;
  logic [63:0]   prod_q;
  logic [47:0]   pn_q;
  logic [5:0]    m_q;
  logic [15:0]   ybits_q;
  logic          out_valid_q, out_last_q;
  logic [15:0]   out_bits_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rsm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // input side
  logic        in_acc;
  logic [15:0] x_sat;
  logic [6:0]  eff_len, fill_nx;
  logic        row_done;
  logic signed [43:0] x_val;

  always_comb begin
    x_sat = x_bits_i;
    if (x_bits_i[14:10] == 5'h1F) begin
      x_sat = (x_bits_i[9:0] != 10'd0) ? PosMaxBits : {x_bits_i[15], PosMaxBits[14:0]};
    end
  end

  assign x_val   = half_val(x_sat);
  assign eff_len = (row_len_q == 7'd0) ? 7'd1 : ((row_len_q > MaxLen) ? MaxLen : row_len_q);
  assign fill_nx = 7'(fill_q) + 7'd1;
  assign row_done = fill_nx >= eff_len;
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc = in_valid_i && !in_stall_o;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  always_comb begin
    mul_a = {1'b0, r_q};
    mul_b = y_q;
    case (state_q)
      S_SQ:    mul_b = r_q;
      S_OMUL: begin
        mul_a = inv_q;
        mul_b = {16'd0, ex_rd_q};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // difference, exp rounding, conversions
  logic [43:0] mag;
  logic [43:0] d_rnd;
  logic [14:0] d_val;
  logic [63:0] sq_rnd;
  logic [32:0] e_rnd;
  logic [15:0] e_val;
  logic        last_i;
  logic [10:0] q_small;
  logic [11:0] q_big;
  logic [4:0]  e_exp;
  logic [16:0] bits_big;

  assign mag   = 44'(vmax_q - half_val(st_rd_q));
  assign d_rnd = (mag + 44'd8192) >> 14;
  assign d_val = (d_rnd > 44'd16384) ? 15'd16384 : d_rnd[14:0];
  assign sq_rnd = prod_q + (64'd1 << 30);
  assign e_rnd  = {1'b0, r_q} + 33'd16384;
  assign e_val  = (e_rnd[32:15] > 18'd65535) ? 16'hFFFF : e_rnd[30:15];
  assign last_i = (CW'({1'b0, idx_q}) + CW'(1)) == n_q;

  assign q_small = {1'b0, prod_q[17:8]}
                 + 11'(prod_q[7] & ((|prod_q[6:0]) | prod_q[8]));
  assign q_big   = {1'b0, pn_q[47:37]}
                 + 12'(pn_q[36] & ((|pn_q[35:0]) | pn_q[37]));
  assign e_exp   = 5'(m_q - 6'd17);
  assign bits_big = {2'b0, e_exp, 10'd0} + {5'd0, q_big} - 17'd1024;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && row_done) state_d = S_RD;
      S_RD:    state_d = S_DIFF;
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = S_DIVS;
      S_DIVS:  state_d = S_DIVW;
      S_DIVW:  if (div_rsp.done) state_d = (k_q == 4'd1) ? S_SQ : S_MUL;
      S_SQ:    state_d = S_SQR;
      S_SQR:   state_d = (sq_q == 2'd3) ? S_EXPW : S_SQ;
      S_EXPW:  state_d = last_i ? S_RECS : S_RD;
      S_RECS:  state_d = S_RECW;
      S_RECW:  if (div_rsp.done) state_d = S_ORD;
      S_ORD:   state_d = S_OMUL;
      S_OMUL:  state_d = S_OCONV;
      S_OCONV: state_d = (prod_q[47:18] == 30'd0) ? S_OEMIT : S_ONORM;
      S_ONORM: if (pn_q[47]) state_d = S_OEMIT;
      S_OEMIT: if (!out_valid_q || !out_stall_i) state_d = last_i ? S_IDLE : S_ORD;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  logic out_load, ex_we;
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, prod_q[62:31]};
    div_req.divisor  = {20'd0, k_q};
    out_load = 1'b0;
    ex_we    = 1'b0;
    unique case (state_q)
      S_DIVS: div_req.start = 1'b1;
      S_RECS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b1, 9'd0, sum_q[23:1]};
        div_req.divisor  = sum_q;
      end
      S_EXPW:  ex_we = 1'b1;
      S_OEMIT: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_len_q   <= 7'd64;
      fill_q      <= '0;
      vmax_q      <= NegInfVal;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && !paddr[2]) row_len_q <= pwdata[6:0];
      if (in_acc) begin
        if (x_val > vmax_q) vmax_q <= x_val;
        fill_q <= row_done ? '0 : CW'(fill_nx);
      end
      if (ex_we) begin
        sum_q <= sum_q + {8'd0, e_val};
        idx_q <= last_i ? '0 : idx_q + AW'(1);
      end
      if (out_load) begin
        idx_q <= last_i ? '0 : idx_q + AW'(1);
        if (last_i) begin
          vmax_q <= NegInfVal;
          sum_q  <= '0;
        end
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_mem[fill_q[AW-1:0]] <= x_sat;
      n_q <= CW'(fill_nx);
    end
    if (state_q == S_RD) st_rd_q <= st_mem[idx_q];
    if (ex_we) ex_mem[idx_q] <= e_val;
    if (state_q == S_ORD) ex_rd_q <= ex_mem[idx_q];
    if (out_load) begin
      out_bits_q <= ybits_q;
      out_last_q <= last_i;
    end
    unique case (state_q)
      S_DIFF: begin
        y_q <= {d_val, 17'd0};
        r_q <= Q31One;
        k_q <= 4'd12;
        sq_q <= 2'd0;
      end
      S_MUL, S_SQ, S_OMUL: prod_q <= mul_p[63:0];
      S_DIVW: if (div_rsp.done) begin
        r_q <= Q31One - div_rsp.quot[31:0];
        k_q <= k_q - 4'd1;
      end
      S_SQR: begin
        r_q  <= sq_rnd[62:31];
        sq_q <= sq_q + 2'd1;
      end
      S_RECW: if (div_rsp.done) inv_q <= (sum_q == 24'd0) ? 33'd0 : div_rsp.quot;
      S_OCONV: begin
        ybits_q <= {5'd0, q_small};
        pn_q    <= prod_q[47:0];
        m_q     <= 6'd47;
      end
      S_ONORM: begin
        if (pn_q[47]) ybits_q <= bits_big[15:0];
        else begin
          pn_q <= {pn_q[46:0], 1'b0};
          m_q  <= m_q - 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign y_bits_o    = out_bits_q;
  assign row_last_o  = out_last_q;
  assign prdata      = paddr[2] ? 32'd0 : {25'd0, row_len_q};
  assign pready      = 1'b1;

  // a quotient arrives only while the sequencer waits for one
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVW || state_q == S_RECW))
    else $error("divider result while not waiting");

  // a loading row never holds a full store
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> 7'(fill_q) < MaxLen)
    else $error("row store overfilled");

  // a row in process always has a finite max
  a_vmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> vmax_q != NegInfVal)
    else $error("row processed without elements");

endmodule

`default_nettype wire

[dv/row_softmax_fp16_core_tb.sv]
// ----------------------------------------------------------------------------
// row_softmax_fp16_core_tb: self-checking bench for the row softmax core
// Drives rows of half-precision elements under several idling mixes, writes
// row_length over the APB port, predicts every softmax result in fixed point
// and compares each output item in order against the predicted queue.
// ----------------------------------------------------------------------------
`default_nettype none

module row_softmax_fp16_core_tb;

  localparam int unsigned MaxRow = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] x_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] y_bits_o;
  logic        row_last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  row_softmax_fp16_core #(.MAX_ROW(MaxRow)) dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] row_mem [MaxRow];
  int unsigned row_fill;
  logic [15:0] row_peak;
  logic [6:0]  row_len_cfg;

  logic [15:0] softmax_q [$];
  logic        last_q [$];

  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;

  function automatic logic [15:0] clamp_half(logic [15:0] b);
    if (b[14:10] == 5'h1F) begin
      if (b[9:0] != 0) return rsm_pkg::PosMaxBits;
      return {b[15], rsm_pkg::PosMaxBits[14:0]};
    end
    return b;
  endfunction

  // value in units of 2^-24; infinity sits below/above all finite values
  function automatic longint half_units(logic [15:0] b);
    longint mag;
    if (b[14:10] == 5'h1F) mag = 64'sd1 <<< 42;
    else if (b[14:10] == 0) mag = b[9:0];
    else mag = longint'({1'b1, b[9:0]}) <<< (b[14:10] - 1);
    return b[15] ? -mag : mag;
  endfunction

  function automatic logic [31:0] exp_q16(logic [63:0] d);
    logic [63:0] y, r;
    y = d << 17;
    r = 64'(rsm_pkg::Q31One);
    for (int k = 12; k >= 1; k--) r = 64'(rsm_pkg::Q31One) - ((y * r) >> 31) / k;
    for (int i = 0; i < 4; i++) r = (r * r + (64'd1 << 30)) >> 31;
    r = (r + (64'd1 << 14)) >> 15;
    if (r > 65535) r = 65535;
    return r[31:0];
  endfunction

  function automatic logic [15:0] q32_half(logic [63:0] p);
    int m, shift;
    logic [63:0] q, rem, halfway;
    int bits;
    if (p == 0) return 16'h0000;
    m = 0;
    while (m < 63 && (p >> (m + 1)) != 0) m++;
    shift = (m >= 18) ? m - 10 : 8;
    q = p >> shift;
    rem = p & ((64'd1 << shift) - 1);
    halfway = 64'd1 << (shift - 1);
    if (rem > halfway || (rem == halfway && q[0])) q++;
    if (m >= 18) bits = ((m - 17) << 10) + int'(q) - 1024;
    else bits = int'(q);
    return bits[15:0];
  endfunction

  // load one element; when the row is complete, queue its softmax results
  task automatic load_element(logic [15:0] raw);
    logic [15:0] x;
    int unsigned eff, n;
    logic [31:0] ex [MaxRow];
    logic [63:0] sum, inv, mag, d;
    x = clamp_half(raw);
    if (row_fill < MaxRow) begin
      row_mem[row_fill] = x;
      row_fill++;
    end
    if (half_units(x) > half_units(row_peak)) row_peak = x;
    eff = (row_len_cfg == 0) ? 1 : (row_len_cfg > MaxRow) ? MaxRow : row_len_cfg;
    if (row_fill < eff) return;
    n = row_fill;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      mag = 64'(half_units(row_peak) - half_units(row_mem[i]));
      d = (mag + 8192) >> 14;
      if (d > 16384) d = 16384;
      ex[i] = exp_q16(d);
      sum += ex[i];
    end
    sum &= 64'hFF_FFFF;
    inv = (sum != 0) ? ((64'd1 << 32) + (sum >> 1)) / sum : 0;
    for (int i = 0; i < n; i++) begin
      softmax_q.push_back(q32_half(64'(ex[i]) * inv));
      last_q.push_back(i + 1 == n);
    end
    row_fill = 0;
    row_peak = rsm_pkg::NegInfBits;
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_stall_i <= (hold_cycles > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (softmax_q.size() == 0) begin
        report_mismatch("unexpected item", y_bits_o, 16'h0);
      end else begin
        if (y_bits_o !== softmax_q[0]) report_mismatch("y_bits", y_bits_o, softmax_q[0]);
        if (row_last_o !== last_q[0]) report_mismatch("row_last", row_last_o, last_q[0]);
        void'(softmax_q.pop_front());
        void'(last_q.pop_front());
      end
    end
  end

  task automatic send_item(logic [15:0] v);
    in_valid_i <= 1'b1;
    x_bits_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    load_element(v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_row_length(logic [31:0] v);
    in_valid_i <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    row_len_cfg = v[6:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (softmax_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_half();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(12, 17)), 10'($urandom)};
  endfunction

  // reset length, then over-range length; hold the receiver off so the input stalls
  task automatic test_full_row_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(rand_half());
    send_item(rand_half());
    write_row_length(100);
    hold_cycles = 40000;
    for (int i = 0; i < 62; i++) send_item(rand_half());
    // these start the next row, taken only once the held row has been emitted
    for (int i = 0; i < 3; i++) send_item(rand_half());
    drain();
  endtask

  // shorten the length under a partial row: the next element ends it
  task automatic test_mid_row_length();
    write_row_length(1);
    send_item(16'h3C00);
    drain();
  endtask

  task automatic test_special_values();
    logic [15:0] singles [8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                                 16'h7E00, 16'hFFFF, 16'h7BFF, 16'h0001};
    logic [15:0] pairs [8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                               16'h7E00, 16'h7BFF, 16'h3C00, 16'h3800};
    foreach (singles[i]) send_item(singles[i]);
    drain();
    write_row_length(0);
    send_item(16'hC000);
    send_item(16'h0400);
    drain();
    write_row_length(2);
    foreach (pairs[i]) send_item(pairs[i]);
    drain();
    write_row_length(127);
    write_row_length(3);
    send_item(16'hFBFF);
    send_item(16'h7BFF);
    send_item(16'h0000);
    drain();
  endtask

  task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned len, sent;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    len = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    write_row_length(len);
    sent = 0;
    while (sent < 12) begin
      for (int i = 0; i < len; i++) send_item(rand_half());
      sent += len;
    end
    drain();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    row_fill = 0;
    row_peak = rsm_pkg::NegInfBits;
    row_len_cfg = 7'd64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_row_pressure();
    test_mid_row_length();
    test_special_values();
    test_random_phase(0, 0);
    test_random_phase(80, 0);
    test_random_phase(0, 80);
    test_random_phase(30, 30);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/rsm_pkg.sv
rtl/core/rsm_div.sv
rtl/core/row_softmax_fp16_core.sv
dv/row_softmax_fp16_core_tb.sv
